// File: hdl/gsa_pkg.sv
// Shared types, constants and codes of the generational slot allocator.
package gsa_pkg;

    localparam int MAX_SLOTS  = 1024;
    localparam int SLOT_W     = $clog2(MAX_SLOTS);
    localparam int CNT_W      = SLOT_W + 1;
    localparam int GEN_BITS   = 32;
    localparam int POOL_W     = 16;
    localparam int TOTAL_W    = 32;
    localparam int OP_W       = 3;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [OP_W-1:0] OP_ALLOC  = 3'd0;
    localparam logic [OP_W-1:0] OP_FREE   = 3'd1;
    localparam logic [OP_W-1:0] OP_CHECK  = 3'd2;
    localparam logic [OP_W-1:0] OP_RESET  = 3'd3;
    localparam logic [OP_W-1:0] OP_CREATE = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [STAT_W-1:0] ST_INVALID   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_IDENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_CAP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP_LIMIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GROW_EN    = 2'd3;

    localparam logic [POOL_W-1:0] POOL_IDENT_RST = 16'd1;
    localparam logic [CNT_W-1:0]  START_CAP_RST  = CNT_W'(64);
    localparam logic [CNT_W-1:0]  CAP_LIMIT_RST  = '0;
    localparam logic              GROW_EN_RST    = 1'b0;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [POOL_W-1:0]   handle_pool;
        logic [SLOT_W-1:0]   handle_index;
        logic [GEN_BITS-1:0] handle_generation;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [SLOT_W-1:0]   slot_out;
        logic [GEN_BITS-1:0] generation_out;
        logic [POOL_W-1:0]   pool_out;
        logic [CNT_W-1:0]    capacity_now;
        logic [CNT_W-1:0]    in_use_count;
        logic [CNT_W-1:0]    free_now;
        logic [CNT_W-1:0]    peak_in_use;
        logic [TOTAL_W-1:0]  alloc_total;
    } t_res;

    typedef struct packed {
        logic load_req;
        logic clear_step;
        logic create;
        logic exhaust;
        logic invalid;
        logic grow_begin;
        logic grow_step;
        logic grow_done;
        logic refill_begin;
        logic refill_step;
        logic refill_done;
        logic alloc_rd_gen;
        logic alloc_commit;
        logic handle_eval;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            top_zero;
        logic            grow_ok;
        logic            clear_last;
        logic            grow_last;
        logic            refill_last;
        logic            out_free;
    } t_sts;

endpackage

// File: hdl/generational_slot_allocator.sv
// Top level of the generational slot allocator.
// A request on the input channel carries an operation and a handle; each request gives
// exactly one result on the output channel, held in an output register until taken.
// Configuration writes go through a separate valid/ready channel that is always ready;
// they are meant to happen while no request is in flight.
// Steps from acceptance to result: decode, slot read and generation read for an allocate
// from a non-empty stack; decode and handle check for free and check; decode alone for
// an exhausted allocate or an unknown operation. With growth, an allocate on an empty
// stack first pushes each new slot, then decodes again. Reset pool refills the
// slots below the capacity, create clears all 1024 slots; both are set by the single
// write port of the generation memory, one slot per cycle. One request is in work at
// a time, so a new request is taken in the cycle after the previous result has been
// loaded into the output register. After reset the block sweeps all 1024 slots
// of both memories, stalling input meanwhile, then holds a start capacity of 64 slots.
// While the receiver stalls, the result stays put and a finished request waits for
// the output register before the next request is taken.
module generational_slot_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  gsa_pkg::t_req                   i_in_req,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output gsa_pkg::t_res                   o_out_res,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [gsa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gsa_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    gsa_pkg::t_cmd w_cmd;
    gsa_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    gsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    gsa_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_req    (i_in_req),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_res   (o_out_res),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("Request taken while another request was in work.");

    a_count_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (({1'b0, o_out_res.in_use_count} + {1'b0, o_out_res.free_now})
                         == {1'b0, o_out_res.capacity_now}))
        else $error("Allocated and free slots do not add up to the capacity.");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_sts.out_free)
        else $error("Result loaded over a result still waiting.");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.out_load))
        else $error("Result became valid without a load.");

endmodule

// File: hdl/gsa_dpath.sv
// Datapath of the slot allocator: registers, free stack and generation memories, counters.
module gsa_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [gsa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gsa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  gsa_pkg::t_req                   i_in_req,
    input  logic                            i_out_stall,
    output logic                            o_out_valid,
    output gsa_pkg::t_res                   o_out_res,
    input  gsa_pkg::t_cmd                   i_cmd,
    output gsa_pkg::t_sts                   o_sts
);

    logic [gsa_pkg::POOL_W-1:0]   r_pool_ident;
    logic [gsa_pkg::CNT_W-1:0]    r_start_cap;
    logic [gsa_pkg::CNT_W-1:0]    r_cap_limit;
    logic                         r_grow_en;

    gsa_pkg::t_req                r_req, n_req;
    logic [gsa_pkg::CNT_W-1:0]    r_cap, n_cap;
    logic [gsa_pkg::CNT_W-1:0]    r_top, n_top;
    logic [gsa_pkg::CNT_W-1:0]    r_live, n_live;
    logic [gsa_pkg::CNT_W-1:0]    r_peak, n_peak;
    logic [gsa_pkg::TOTAL_W-1:0]  r_total, n_total;
    logic [gsa_pkg::CNT_W-1:0]    r_ncap, n_ncap;
    logic [gsa_pkg::SLOT_W-1:0]   r_sweep, n_sweep;
    logic [gsa_pkg::STAT_W-1:0]   r_res_status, n_res_status;
    logic [gsa_pkg::SLOT_W-1:0]   r_res_slot, n_res_slot;
    logic [gsa_pkg::GEN_BITS-1:0] r_res_gen, n_res_gen;
    logic [gsa_pkg::POOL_W-1:0]   r_res_pool, n_res_pool;
    logic                         r_rmw_vld;
    logic [gsa_pkg::SLOT_W-1:0]   r_rmw_addr;
    logic                         r_out_vld;
    gsa_pkg::t_res                r_out;

    logic [gsa_pkg::SLOT_W-1:0]   r_stack_mem [gsa_pkg::MAX_SLOTS];
    logic [gsa_pkg::GEN_BITS-1:0] r_gen_mem   [gsa_pkg::MAX_SLOTS];
    logic [gsa_pkg::SLOT_W-1:0]   r_stack_q;
    logic [gsa_pkg::GEN_BITS-1:0] r_gen_q;

    logic [gsa_pkg::CNT_W-1:0]    w_start;
    logic [gsa_pkg::CNT_W-1:0]    w_lim;
    logic                         w_grow_ok;
    logic [gsa_pkg::CNT_W:0]      w_dbl;
    logic [gsa_pkg::CNT_W-1:0]    w_ncap;
    logic [gsa_pkg::CNT_W-1:0]    w_top_m1;
    logic [gsa_pkg::CNT_W-1:0]    w_cap_m1;
    logic [gsa_pkg::CNT_W-1:0]    w_ncap_m1;
    logic                         w_hok;
    logic                         w_free_ok;
    logic                         w_is_free;
    logic                         w_out_free;

    logic                         w_stk_we;
    logic [gsa_pkg::SLOT_W-1:0]   w_stk_wa;
    logic [gsa_pkg::SLOT_W-1:0]   w_stk_wd;
    logic [gsa_pkg::SLOT_W-1:0]   w_stk_ra;
    logic                         w_gen_we;
    logic [gsa_pkg::SLOT_W-1:0]   w_gen_wa;
    logic [gsa_pkg::GEN_BITS-1:0] w_gen_wd;
    logic [gsa_pkg::SLOT_W-1:0]   w_gen_ra;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_ident <= gsa_pkg::POOL_IDENT_RST;
            r_start_cap  <= gsa_pkg::START_CAP_RST;
            r_cap_limit  <= gsa_pkg::CAP_LIMIT_RST;
            r_grow_en    <= gsa_pkg::GROW_EN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gsa_pkg::CFG_POOL_IDENT: r_pool_ident <= i_cfg_data[gsa_pkg::POOL_W-1:0];
                gsa_pkg::CFG_START_CAP:  r_start_cap  <= i_cfg_data[gsa_pkg::CNT_W-1:0];
                gsa_pkg::CFG_CAP_LIMIT:  r_cap_limit  <= i_cfg_data[gsa_pkg::CNT_W-1:0];
                gsa_pkg::CFG_GROW_EN:    r_grow_en    <= i_cfg_data[0];
            endcase
        end
    end

    always_comb begin
        if (r_start_cap == '0) begin
            w_start = gsa_pkg::CNT_W'(1);
        end else if (r_start_cap > gsa_pkg::CNT_W'(gsa_pkg::MAX_SLOTS)) begin
            w_start = gsa_pkg::CNT_W'(gsa_pkg::MAX_SLOTS);
        end else begin
            w_start = r_start_cap;
        end
        if (r_cap_limit == '0 || r_cap_limit > gsa_pkg::CNT_W'(gsa_pkg::MAX_SLOTS)) begin
            w_lim = gsa_pkg::CNT_W'(gsa_pkg::MAX_SLOTS);
        end else begin
            w_lim = r_cap_limit;
        end
        w_grow_ok = r_grow_en && (r_cap < w_lim);
        w_dbl     = {r_cap, 1'b0};
        w_ncap    = (w_dbl > {1'b0, w_lim}) ? w_lim : w_dbl[gsa_pkg::CNT_W-1:0];
    end

    assign w_top_m1   = r_top - gsa_pkg::CNT_W'(1);
    assign w_cap_m1   = r_cap - gsa_pkg::CNT_W'(1);
    assign w_ncap_m1  = r_ncap - gsa_pkg::CNT_W'(1);
    assign w_is_free  = (r_req.op == gsa_pkg::OP_FREE);
    assign w_hok      = (r_req.handle_pool == r_pool_ident)
                     && ({1'b0, r_req.handle_index} < r_cap)
                     && (r_gen_q == r_req.handle_generation);
    assign w_free_ok  = w_hok && (r_top < r_cap);
    assign w_out_free = !r_out_vld || !i_out_stall;

    // Memory port selection.
    always_comb begin
        w_stk_we = 1'b0;
        w_stk_wa = r_sweep;
        w_stk_wd = r_sweep;
        if (i_cmd.clear_step || i_cmd.refill_step) begin
            w_stk_we = 1'b1;
        end else if (i_cmd.grow_step) begin
            w_stk_we = 1'b1;
            w_stk_wa = r_top[gsa_pkg::SLOT_W-1:0];
        end else if (i_cmd.handle_eval && w_is_free && w_free_ok) begin
            w_stk_we = 1'b1;
            w_stk_wa = r_top[gsa_pkg::SLOT_W-1:0];
            w_stk_wd = r_req.handle_index;
        end
        w_stk_ra = w_top_m1[gsa_pkg::SLOT_W-1:0];

        w_gen_we = 1'b0;
        w_gen_wa = r_sweep;
        w_gen_wd = '0;
        if (i_cmd.clear_step || i_cmd.grow_step) begin
            w_gen_we = 1'b1;
        end else if (r_rmw_vld) begin
            w_gen_we = 1'b1;
            w_gen_wa = r_rmw_addr;
            w_gen_wd = r_gen_q + gsa_pkg::GEN_BITS'(1);
        end else if (i_cmd.handle_eval && w_is_free && w_free_ok) begin
            w_gen_we = 1'b1;
            w_gen_wa = r_req.handle_index;
            w_gen_wd = r_gen_q + gsa_pkg::GEN_BITS'(1);
        end
        if (i_cmd.refill_step) begin
            w_gen_ra = r_sweep;
        end else if (i_cmd.alloc_rd_gen) begin
            w_gen_ra = r_stack_q;
        end else begin
            w_gen_ra = r_req.handle_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stk_we) begin
            r_stack_mem[w_stk_wa] <= w_stk_wd;
        end
        r_stack_q <= r_stack_mem[w_stk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_gen_we) begin
            r_gen_mem[w_gen_wa] <= w_gen_wd;
        end
        r_gen_q <= r_gen_mem[w_gen_ra];
    end

    // Counter and result updates.
    always_comb begin
        n_req        = r_req;
        n_cap        = r_cap;
        n_top        = r_top;
        n_live       = r_live;
        n_peak       = r_peak;
        n_total      = r_total;
        n_ncap       = r_ncap;
        n_sweep      = r_sweep;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_res_gen    = r_res_gen;
        n_res_pool   = r_res_pool;

        if (i_cmd.load_req) begin
            n_req        = i_in_req;
            n_res_status = gsa_pkg::ST_OK;
            n_res_slot   = '0;
            n_res_gen    = '0;
            n_res_pool   = '0;
        end
        if (i_cmd.create) begin
            n_cap   = w_start;
            n_top   = w_start;
            n_live  = '0;
            n_peak  = '0;
            n_total = '0;
            n_sweep = '0;
        end
        if (i_cmd.refill_begin) begin
            n_sweep = '0;
        end
        if (i_cmd.clear_step || i_cmd.refill_step || i_cmd.grow_step) begin
            n_sweep = r_sweep + gsa_pkg::SLOT_W'(1);
        end
        if (i_cmd.grow_step) begin
            n_top = r_top + gsa_pkg::CNT_W'(1);
        end
        if (i_cmd.grow_begin) begin
            n_sweep = r_cap[gsa_pkg::SLOT_W-1:0];
            n_ncap  = w_ncap;
        end
        if (i_cmd.grow_done) begin
            n_cap = r_ncap;
        end
        if (i_cmd.refill_done) begin
            n_top  = r_cap;
            n_live = '0;
        end
        if (i_cmd.exhaust) begin
            n_res_status = gsa_pkg::ST_EXHAUSTED;
        end
        if (i_cmd.invalid) begin
            n_res_status = gsa_pkg::ST_INVALID;
        end
        if (i_cmd.alloc_rd_gen) begin
            n_res_slot = r_stack_q;
        end
        if (i_cmd.alloc_commit) begin
            n_res_gen  = r_gen_q;
            n_res_pool = r_pool_ident;
            n_top      = w_top_m1;
            n_live     = r_live + gsa_pkg::CNT_W'(1);
            n_total    = r_total + gsa_pkg::TOTAL_W'(1);
            if (n_live > r_peak) begin
                n_peak = n_live;
            end
        end
        if (i_cmd.handle_eval) begin
            if (w_is_free) begin
                if (w_free_ok) begin
                    n_top = r_top + gsa_pkg::CNT_W'(1);
                    if (r_live != '0) begin
                        n_live = r_live - gsa_pkg::CNT_W'(1);
                    end
                end else begin
                    n_res_status = gsa_pkg::ST_INVALID;
                end
            end else begin
                n_res_status = w_hok ? gsa_pkg::ST_OK : gsa_pkg::ST_INVALID;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= gsa_pkg::START_CAP_RST;
            r_top     <= gsa_pkg::START_CAP_RST;
            r_live    <= '0;
            r_peak    <= '0;
            r_total   <= '0;
            r_sweep   <= '0;
            r_rmw_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_cap     <= n_cap;
            r_top     <= n_top;
            r_live    <= n_live;
            r_peak    <= n_peak;
            r_total   <= n_total;
            r_sweep   <= n_sweep;
            r_rmw_vld <= i_cmd.refill_step;
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_ncap       <= n_ncap;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_gen    <= n_res_gen;
        r_res_pool   <= n_res_pool;
        r_rmw_addr   <= r_sweep;
        if (i_cmd.out_load) begin
            r_out.status         <= r_res_status;
            r_out.slot_out       <= r_res_slot;
            r_out.generation_out <= r_res_gen;
            r_out.pool_out       <= r_res_pool;
            r_out.capacity_now   <= r_cap;
            r_out.in_use_count   <= r_live;
            r_out.free_now       <= r_top;
            r_out.peak_in_use    <= r_peak;
            r_out.alloc_total    <= r_total;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_res   = r_out;

    assign o_sts.op          = r_req.op;
    assign o_sts.top_zero    = (r_top == '0);
    assign o_sts.grow_ok     = w_grow_ok;
    assign o_sts.clear_last  = (r_sweep == gsa_pkg::SLOT_W'(gsa_pkg::MAX_SLOTS - 1));
    assign o_sts.grow_last   = ({1'b0, r_sweep} == w_ncap_m1);
    assign o_sts.refill_last = ({1'b0, r_sweep} == w_cap_m1);
    assign o_sts.out_free    = w_out_free;

endmodule

// File: hdl/gsa_ctrl.sv
// Controller state machine of the slot allocator.
module gsa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  gsa_pkg::t_sts i_sts,
    output gsa_pkg::t_cmd o_cmd
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_ASLOT  = 4'd3;
    localparam logic [3:0] S_AGEN   = 4'd4;
    localparam logic [3:0] S_HCHK   = 4'd5;
    localparam logic [3:0] S_GROW   = 4'd6;
    localparam logic [3:0] S_REFILL = 4'd7;
    localparam logic [3:0] S_RFEND  = 4'd8;
    localparam logic [3:0] S_RESULT = 4'd9;

    logic [3:0] r_state, n_state;
    logic       r_reply, n_reply;

    always_comb begin
        n_state = r_state;
        n_reply = r_reply;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = r_reply ? S_RESULT : S_IDLE;
                    n_reply = 1'b0;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.op) inside
                    gsa_pkg::OP_ALLOC: begin
                        if (!i_sts.top_zero) begin
                            n_state = S_ASLOT;
                        end else if (i_sts.grow_ok) begin
                            o_cmd.grow_begin = 1'b1;
                            n_state          = S_GROW;
                        end else begin
                            o_cmd.exhaust = 1'b1;
                            n_state       = S_RESULT;
                        end
                    end
                    gsa_pkg::OP_FREE, gsa_pkg::OP_CHECK: begin
                        n_state = S_HCHK;
                    end
                    gsa_pkg::OP_RESET: begin
                        o_cmd.refill_begin = 1'b1;
                        n_state            = S_REFILL;
                    end
                    gsa_pkg::OP_CREATE: begin
                        o_cmd.create = 1'b1;
                        n_reply      = 1'b1;
                        n_state      = S_CLEAR;
                    end
                    default: begin
                        o_cmd.invalid = 1'b1;
                        n_state       = S_RESULT;
                    end
                endcase
            end
            S_ASLOT: begin
                o_cmd.alloc_rd_gen = 1'b1;
                n_state            = S_AGEN;
            end
            S_AGEN: begin
                o_cmd.alloc_commit = 1'b1;
                n_state            = S_RESULT;
            end
            S_HCHK: begin
                o_cmd.handle_eval = 1'b1;
                n_state           = S_RESULT;
            end
            S_GROW: begin
                o_cmd.grow_step = 1'b1;
                if (i_sts.grow_last) begin
                    o_cmd.grow_done = 1'b1;
                    n_state         = S_DECODE;
                end
            end
            S_REFILL: begin
                o_cmd.refill_step = 1'b1;
                if (i_sts.refill_last) begin
                    n_state = S_RFEND;
                end
            end
            S_RFEND: begin
                o_cmd.refill_done = 1'b1;
                n_state           = S_RESULT;
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_reply <= 1'b0;
        end else begin
            r_state <= n_state;
            r_reply <= n_reply;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// File: dv/generational_slot_allocator_test.sv
// Self-checking testbench of the generational slot allocator with directed and random requests.
module generational_slot_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;
    localparam int PRINT_LIMIT = 20;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 215;

    typedef struct packed {
        logic [gsa_pkg::POOL_W-1:0]   pool;
        logic [gsa_pkg::SLOT_W-1:0]   index;
        logic [gsa_pkg::GEN_BITS-1:0] gen;
    } t_handle;

    logic                           i_clk     = 1'b0;
    logic                           i_rst_n   = 1'b0;
    logic                           in_valid  = 1'b0;
    gsa_pkg::t_req                  in_req    = '0;
    logic                           o_in_stall;
    logic                           o_out_valid;
    logic                           out_stall = 1'b0;
    gsa_pkg::t_res                  o_out_res;
    logic                           cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [gsa_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [gsa_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // Predicted register contents.
    logic [gsa_pkg::POOL_W-1:0] cfg_pool  = gsa_pkg::POOL_IDENT_RST;
    logic [gsa_pkg::CNT_W-1:0]  cfg_start = gsa_pkg::START_CAP_RST;
    logic [gsa_pkg::CNT_W-1:0]  cfg_limit = gsa_pkg::CAP_LIMIT_RST;
    logic                       cfg_grow  = gsa_pkg::GROW_EN_RST;

    // Predicted pool state.
    logic [gsa_pkg::SLOT_W-1:0]   slot_stack [gsa_pkg::MAX_SLOTS];
    logic [gsa_pkg::GEN_BITS-1:0] slot_gen   [gsa_pkg::MAX_SLOTS];
    int                           cap_now;
    int                           stack_depth;
    int                           live_now;
    int                           live_peak;
    logic [gsa_pkg::TOTAL_W-1:0]  alloc_count;

    gsa_pkg::t_req request_queue[$];
    gsa_pkg::t_res outcomes_due[$];
    t_handle       live_handles[$];
    t_handle       old_handles[$];

    logic in_fire       = 1'b0;
    int   queued_count  = 0;
    int   accepted_count = 0;
    int   results_seen  = 0;
    int   idle_cycles   = 0;
    int   errors        = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_len      = 0;
    int   n_alloc       = 0;
    int   n_exhausted   = 0;
    int   n_rejected    = 0;
    int   n_growth      = 0;

    generational_slot_allocator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_res   (o_out_res),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void rebuild_pool();
        if (cfg_start == 0) begin
            cap_now = 1;
        end else if (cfg_start > gsa_pkg::MAX_SLOTS) begin
            cap_now = gsa_pkg::MAX_SLOTS;
        end else begin
            cap_now = int'(cfg_start);
        end
        for (int i = 0; i < gsa_pkg::MAX_SLOTS; i++) begin
            slot_gen[i]   = '0;
            slot_stack[i] = (i < cap_now) ? gsa_pkg::SLOT_W'(i) : '0;
        end
        stack_depth = cap_now;
        live_now    = 0;
        live_peak   = 0;
        alloc_count = '0;
        live_handles.delete();
    endfunction

    function automatic logic handle_valid(gsa_pkg::t_req r);
        return r.handle_pool == cfg_pool && int'(r.handle_index) < cap_now &&
               slot_gen[r.handle_index] == r.handle_generation;
    endfunction

    function automatic gsa_pkg::t_res next_outcome(gsa_pkg::t_req r);
        gsa_pkg::t_res res;
        t_handle       h;
        int            lim;
        int            ncap;
        res = '0;
        case (r.op)
            gsa_pkg::OP_ALLOC: begin
                if (stack_depth == 0) begin
                    lim = (cfg_limit == 0 || cfg_limit > gsa_pkg::MAX_SLOTS) ?
                          gsa_pkg::MAX_SLOTS : int'(cfg_limit);
                    if (cfg_grow && cap_now < lim) begin
                        ncap = (cap_now * 2 > lim) ? lim : cap_now * 2;
                        for (int i = cap_now; i < ncap; i++) begin
                            slot_gen[i] = '0;
                            slot_stack[stack_depth] = gsa_pkg::SLOT_W'(i);
                            stack_depth++;
                        end
                        cap_now = ncap;
                        n_growth++;
                    end
                end
                if (stack_depth > 0) begin
                    stack_depth--;
                    res.slot_out       = slot_stack[stack_depth];
                    res.generation_out = slot_gen[res.slot_out];
                    res.pool_out       = cfg_pool;
                    live_now++;
                    alloc_count++;
                    if (live_now > live_peak) begin
                        live_peak = live_now;
                    end
                    h = '{cfg_pool, res.slot_out, res.generation_out};
                    live_handles.push_back(h);
                    n_alloc++;
                end else begin
                    res.status = gsa_pkg::ST_EXHAUSTED;
                    n_exhausted++;
                end
            end
            gsa_pkg::OP_FREE: begin
                if (!handle_valid(r) || stack_depth >= cap_now) begin
                    res.status = gsa_pkg::ST_INVALID;
                end else begin
                    slot_stack[stack_depth] = r.handle_index;
                    stack_depth++;
                    if (live_now > 0) begin
                        live_now--;
                    end
                    slot_gen[r.handle_index] = slot_gen[r.handle_index] + 1'b1;
                end
            end
            gsa_pkg::OP_CHECK: begin
                res.status = handle_valid(r) ? gsa_pkg::ST_OK : gsa_pkg::ST_INVALID;
            end
            gsa_pkg::OP_RESET: begin
                for (int i = 0; i < cap_now; i++) begin
                    slot_stack[i] = gsa_pkg::SLOT_W'(i);
                    slot_gen[i]   = slot_gen[i] + 1'b1;
                end
                stack_depth = cap_now;
                live_now    = 0;
                live_handles.delete();
            end
            gsa_pkg::OP_CREATE: begin
                rebuild_pool();
            end
            default: begin
                res.status = gsa_pkg::ST_INVALID;
            end
        endcase
        if (res.status == gsa_pkg::ST_INVALID) begin
            n_rejected++;
        end
        res.capacity_now = gsa_pkg::CNT_W'(cap_now);
        res.in_use_count = gsa_pkg::CNT_W'(live_now);
        res.free_now     = gsa_pkg::CNT_W'(stack_depth);
        res.peak_in_use  = gsa_pkg::CNT_W'(live_peak);
        res.alloc_total  = alloc_count;
        return res;
    endfunction

    function automatic gsa_pkg::t_req make_request();
        gsa_pkg::t_req r;
        t_handle       h;
        int            pick;
        int            k;
        r.op                = gsa_pkg::OP_ALLOC;
        r.handle_pool       = gsa_pkg::POOL_W'($urandom);
        r.handle_index      = gsa_pkg::SLOT_W'($urandom);
        r.handle_generation = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            r.op = gsa_pkg::OP_ALLOC;
        end else if (pick < 78 && live_handles.size() > 0) begin
            k = $urandom_range(0, live_handles.size() - 1);
            h = live_handles[k];
            if (pick < 68) begin
                r.op = gsa_pkg::OP_FREE;
                live_handles.delete(k);
                old_handles.push_back(h);
                if (old_handles.size() > 64) begin
                    void'(old_handles.pop_front());
                end
            end else begin
                r.op = gsa_pkg::OP_CHECK;
            end
            {r.handle_pool, r.handle_index, r.handle_generation} = h;
        end else if (pick < 88) begin
            r.op = $urandom_range(0, 1) ? gsa_pkg::OP_FREE : gsa_pkg::OP_CHECK;
            if (old_handles.size() > 0 && $urandom_range(0, 1)) begin
                h = old_handles[$urandom_range(0, old_handles.size() - 1)];
                {r.handle_pool, r.handle_index, r.handle_generation} = h;
                case ($urandom_range(0, 3))
                    0: r.handle_pool ^= gsa_pkg::POOL_W'(1)
                                        << $urandom_range(0, gsa_pkg::POOL_W - 1);
                    1: r.handle_index ^= gsa_pkg::SLOT_W'(1)
                                         << $urandom_range(0, gsa_pkg::SLOT_W - 1);
                    2: r.handle_generation ^= gsa_pkg::GEN_BITS'(1)
                                              << $urandom_range(0, gsa_pkg::GEN_BITS - 1);
                    default: ;
                endcase
            end
        end else if (pick < 94) begin
            r.op                = $urandom_range(0, 1) ? gsa_pkg::OP_FREE : gsa_pkg::OP_CHECK;
            r.handle_pool       = cfg_pool;
            r.handle_generation = '0;
        end else if (pick < 97) begin
            r.op = gsa_pkg::OP_W'($urandom_range(gsa_pkg::OP_CREATE + 1, 7));
        end else if (pick < 99) begin
            r.op = gsa_pkg::OP_RESET;
        end else begin
            r.op = gsa_pkg::OP_CREATE;
        end
        return r;
    endfunction

    task automatic queue_request(input gsa_pkg::t_req r);
        request_queue.push_back(r);
        queued_count++;
    endtask

    task automatic write_register(input logic [gsa_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [gsa_pkg::CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            gsa_pkg::CFG_POOL_IDENT: cfg_pool  = value;
            gsa_pkg::CFG_START_CAP:  cfg_start = value[gsa_pkg::CNT_W-1:0];
            gsa_pkg::CFG_CAP_LIMIT:  cfg_limit = value[gsa_pkg::CNT_W-1:0];
            gsa_pkg::CFG_GROW_EN:    cfg_grow  = value[0];
        endcase
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= PRINT_LIMIT) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n && (!in_valid || in_fire)) begin
            if (request_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                in_req   <= request_queue.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_len > 0) begin
            hold_len--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        gsa_pkg::t_res due;
        logic          taken;
        in_fire = i_rst_n && in_valid && !o_in_stall;
        taken   = i_rst_n && o_out_valid && !out_stall;
        if (in_fire) begin
            outcomes_due.push_back(next_outcome(in_req));
            accepted_count++;
        end
        if (taken) begin
            results_seen++;
            if (outcomes_due.size() == 0) begin
                errors++;
                if (errors <= PRINT_LIMIT) begin
                    $display("%0t: result with none expected, expected nothing, got %0h",
                             $time, o_out_res);
                end
            end else begin
                due = outcomes_due.pop_front();
                check_field("status", due.status, o_out_res.status);
                check_field("slot_out", due.slot_out, o_out_res.slot_out);
                check_field("generation_out", due.generation_out, o_out_res.generation_out);
                check_field("pool_out", due.pool_out, o_out_res.pool_out);
                check_field("capacity_now", due.capacity_now, o_out_res.capacity_now);
                check_field("in_use_count", due.in_use_count, o_out_res.in_use_count);
                check_field("free_now", due.free_now, o_out_res.free_now);
                check_field("peak_in_use", due.peak_in_use, o_out_res.peak_in_use);
                check_field("alloc_total", due.alloc_total, o_out_res.alloc_total);
            end
        end
        if (in_fire || taken || (cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int pools [PHASES] = '{16'hFFFF, 16'h0000, 16'h5A3C, 16'h0001, 0, 0, 0, 16'h0001};
        int starts[PHASES] = '{1, 2047, 3, 8, 0, 16, 1024, 2};
        int limits[PHASES] = '{0, 2047, 10, 4, 1024, 40, 1, 5};
        int grows [PHASES] = '{1, 0, 1, 1, 1, 0, 1, 1};
        int sends [PHASES] = '{0, 77, 0, 7, 0, 77, 0, 7};
        int recvs [PHASES] = '{0, 0, 77, 7, 0, 0, 77, 7};
        int made;
        int batch;
        logic [gsa_pkg::SLOT_W-1:0] top_slot;

        rebuild_pool();
        top_slot = gsa_pkg::SLOT_W'(gsa_pkg::START_CAP_RST - 1);
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_request(gsa_pkg::t_req'{gsa_pkg::OP_CHECK, gsa_pkg::POOL_IDENT_RST,
                                      gsa_pkg::SLOT_W'(0), gsa_pkg::GEN_BITS'(0)});
        queue_request(gsa_pkg::t_req'{gsa_pkg::OP_FREE, gsa_pkg::POOL_IDENT_RST,
                                      gsa_pkg::SLOT_W'(0), gsa_pkg::GEN_BITS'(0)});
        queue_request(gsa_pkg::t_req'{gsa_pkg::OP_ALLOC, gsa_pkg::POOL_W'(0),
                                      gsa_pkg::SLOT_W'(0), gsa_pkg::GEN_BITS'(0)});
        queue_request(gsa_pkg::t_req'{gsa_pkg::OP_CHECK, gsa_pkg::POOL_IDENT_RST,
                                      top_slot, gsa_pkg::GEN_BITS'(0)});
        queue_request(gsa_pkg::t_req'{gsa_pkg::OP_CHECK, gsa_pkg::POOL_W'(0),
                                      top_slot, gsa_pkg::GEN_BITS'(0)});
        queue_request(gsa_pkg::t_req'{gsa_pkg::OP_CHECK, gsa_pkg::POOL_IDENT_RST,
                                      gsa_pkg::SLOT_W'(gsa_pkg::START_CAP_RST),
                                      gsa_pkg::GEN_BITS'(0)});
        queue_request(gsa_pkg::t_req'{gsa_pkg::OP_CHECK, '1, '1, '1});
        queue_request(gsa_pkg::t_req'{gsa_pkg::OP_FREE, gsa_pkg::POOL_IDENT_RST,
                                      top_slot, gsa_pkg::GEN_BITS'(0)});
        queue_request(gsa_pkg::t_req'{gsa_pkg::OP_FREE, gsa_pkg::POOL_IDENT_RST,
                                      top_slot, gsa_pkg::GEN_BITS'(0)});
        queue_request(gsa_pkg::t_req'{gsa_pkg::OP_ALLOC, '1, '1, '1});
        for (int k = gsa_pkg::OP_CREATE + 1; k < 8; k++) begin
            queue_request(gsa_pkg::t_req'{gsa_pkg::OP_W'(k), gsa_pkg::POOL_W'($urandom),
                                          gsa_pkg::SLOT_W'($urandom), $urandom});
        end
        queue_request(gsa_pkg::t_req'{gsa_pkg::OP_RESET, gsa_pkg::POOL_W'(0),
                                      gsa_pkg::SLOT_W'(0), gsa_pkg::GEN_BITS'(0)});
        queue_request(gsa_pkg::t_req'{gsa_pkg::OP_ALLOC, gsa_pkg::POOL_W'(0),
                                      gsa_pkg::SLOT_W'(0), gsa_pkg::GEN_BITS'(0)});
        queue_request(gsa_pkg::t_req'{gsa_pkg::OP_CHECK, gsa_pkg::POOL_IDENT_RST,
                                      top_slot, gsa_pkg::GEN_BITS'(1)});
        queue_request(gsa_pkg::t_req'{gsa_pkg::OP_CREATE, gsa_pkg::POOL_W'(0),
                                      gsa_pkg::SLOT_W'(0), gsa_pkg::GEN_BITS'(0)});
        wait (results_seen == queued_count);

        write_register(gsa_pkg::CFG_START_CAP, gsa_pkg::CFG_DATA_W'(1));
        write_register(gsa_pkg::CFG_GROW_EN, gsa_pkg::CFG_DATA_W'(0));
        queue_request(gsa_pkg::t_req'{gsa_pkg::OP_CREATE, gsa_pkg::POOL_W'(0),
                                      gsa_pkg::SLOT_W'(0), gsa_pkg::GEN_BITS'(0)});
        queue_request(gsa_pkg::t_req'{gsa_pkg::OP_ALLOC, gsa_pkg::POOL_W'(0),
                                      gsa_pkg::SLOT_W'(0), gsa_pkg::GEN_BITS'(0)});
        queue_request(gsa_pkg::t_req'{gsa_pkg::OP_ALLOC, gsa_pkg::POOL_W'(0),
                                      gsa_pkg::SLOT_W'(0), gsa_pkg::GEN_BITS'(0)});
        queue_request(gsa_pkg::t_req'{gsa_pkg::OP_CHECK, gsa_pkg::POOL_IDENT_RST,
                                      gsa_pkg::SLOT_W'(0), gsa_pkg::GEN_BITS'(0)});
        wait (results_seen == queued_count);

        write_register(gsa_pkg::CFG_GROW_EN, gsa_pkg::CFG_DATA_W'(1));
        queue_request(gsa_pkg::t_req'{gsa_pkg::OP_ALLOC, gsa_pkg::POOL_W'(0),
                                      gsa_pkg::SLOT_W'(0), gsa_pkg::GEN_BITS'(0)});
        queue_request(gsa_pkg::t_req'{gsa_pkg::OP_ALLOC, gsa_pkg::POOL_W'(0),
                                      gsa_pkg::SLOT_W'(0), gsa_pkg::GEN_BITS'(0)});
        wait (results_seen == queued_count);

        for (int p = 0; p < PHASES; p++) begin
            if (p >= 4 && p <= 6) begin
                pools[p] = $urandom_range(0, 65535);
            end
            write_register(gsa_pkg::CFG_POOL_IDENT, gsa_pkg::CFG_DATA_W'(pools[p]));
            write_register(gsa_pkg::CFG_START_CAP, gsa_pkg::CFG_DATA_W'(starts[p]));
            write_register(gsa_pkg::CFG_CAP_LIMIT, gsa_pkg::CFG_DATA_W'(limits[p]));
            write_register(gsa_pkg::CFG_GROW_EN, gsa_pkg::CFG_DATA_W'(grows[p]));
            send_idle_pct = sends[p];
            recv_idle_pct = recvs[p];
            queue_request(gsa_pkg::t_req'{gsa_pkg::OP_CREATE, gsa_pkg::POOL_W'(0),
                                          gsa_pkg::SLOT_W'(0), gsa_pkg::GEN_BITS'(0)});
            made = 0;
            if (p == 4) begin
                wait (results_seen == queued_count);
                hold_len = 500;
                repeat (24) queue_request(make_request());
                made = 24;
            end
            while (made < PHASE_ITEMS) begin
                batch = $urandom_range(1, 6);
                repeat (batch) queue_request(make_request());
                made += batch;
                wait (accepted_count == queued_count);
            end
            wait (results_seen == queued_count);
        end

        repeat (50) @(posedge i_clk);
        if (outcomes_due.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, outcomes_due.size());
        end
        $display("Ran %0d requests over %0d register settings with all idle patterns.",
                 accepted_count, PHASES + 3);
        $display("Allocations %0d, exhausted %0d, rejected %0d, pool growths %0d.",
                 n_alloc, n_exhausted, n_rejected, n_growth);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
